/* src/bsp_pkg.sv */
// Package for the bounded stack with peek: sizes, operation and status codes,
// beat types for both channels and the control state type.
// No dependencies.
`default_nettype none

package bsp_pkg;

    localparam int DEPTH  = 16;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int FLD_W  = 5;
    localparam int CMP_W  = (CNT_W > FLD_W) ? CNT_W : FLD_W;
    localparam int WORD_W = 32;

    localparam logic [FLD_W-1:0] CAP_RST = FLD_W'(16);

    localparam logic [1:0] FN_PUSH = 2'd0;
    localparam logic [1:0] FN_POP  = 2'd1;
    localparam logic [1:0] FN_PEEK = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;
    localparam logic [1:0] ST_BAD_DEPTH = 2'd3;

    typedef struct packed {
        logic        [1:0]        func;
        logic signed [WORD_W-1:0] push_value;
        logic        [FLD_W-1:0]  peek_depth;
    } t_in_item;

    typedef struct packed {
        logic signed [WORD_W-1:0] read_value;
        logic        [1:0]        status;
        logic        [FLD_W-1:0]  entry_count;
        logic                     is_empty;
        logic                     is_full;
    } t_out_item;

    typedef enum logic [0:0] {
        S_IDLE,
        S_LOAD
    } t_state;

endpackage

`default_nettype wire

/* src/bsp_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with registered
// read data that holds while no read is issued. No dependencies.
`default_nettype none

module bsp_ram #(
    parameter int P_WIDTH = 32,
    parameter int P_DEPTH = 16
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_we,
    input  wire logic [$clog2(P_DEPTH)-1:0] i_waddr,
    input  wire logic [P_WIDTH-1:0]         i_wdata,
    input  wire logic                       i_re,
    input  wire logic [$clog2(P_DEPTH)-1:0] i_raddr,
    output logic      [P_WIDTH-1:0]         o_rdata
);

    logic [P_WIDTH-1:0] r_mem [P_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

/* src/bounded_stack_with_peek.sv */
// Top level of the bounded stack with peek.
// Depends on bsp_pkg and bsp_ram.
`default_nettype none

// Bounded LIFO of signed 32-bit words with push, pop and peek at depth (1 is
// the top). Every input beat gives one output beat with the word read (-1 on
// error, 0 for a push), a status, the entry count and empty/full flags; a
// failed operation leaves the stack unchanged. An item passes the accept
// cycle, where the count is updated and a push writes the word store, then
// S_LOAD, which takes the registered store read and holds until the output
// register is free. One item is in flight at a time; a finished result
// waits in the output register while the next beat is taken. The user must
// write capacity on the config channel only while the block is idle; the block
// does not enforce it. 0 acts as 1, values above the store depth as the depth.
module bounded_stack_with_peek
    import bsp_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire t_in_item         i_in_item,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output t_out_item             o_out_item,
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic [FLD_W-1:0] i_cfg_data
);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [FLD_W-1:0] r_cap;
    t_out_item        r_pend, n_pend;
    logic             r_need_rd, n_need_rd;
    logic             r_out_valid;
    t_out_item        r_out_item;
    t_out_item        out_load;

    logic              in_acc, slot_free, load_out;
    logic [CMP_W-1:0]  cap_u, cnt_x, dep_x, cnt_new;
    logic              ram_we, ram_re;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [WORD_W-1:0] ram_rdata;

    assign in_acc    = i_in_valid && o_in_ready;
    assign slot_free = !r_out_valid || i_out_ready;
    assign load_out  = (r_state == S_LOAD) && slot_free;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                if (slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs of the control state
    always_comb begin
        o_in_ready = (r_state == S_IDLE);
    end

    // clamp capacity into 1..DEPTH
    always_comb begin
        cap_u = CMP_W'(r_cap);
        if (cap_u == '0) begin
            cap_u = CMP_W'(1);
        end else if (cap_u > CMP_W'(DEPTH)) begin
            cap_u = CMP_W'(DEPTH);
        end
    end

    // decode the operation on the accept beat
    always_comb begin
        cnt_x     = CMP_W'(r_count);
        dep_x     = CMP_W'(i_in_item.peek_depth);
        cnt_new   = cnt_x;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_waddr = cnt_x[ADDR_W-1:0];
        ram_raddr = cnt_x[ADDR_W-1:0];
        n_need_rd = r_need_rd;
        n_pend    = r_pend;
        if (in_acc) begin
            n_need_rd         = 1'b0;
            n_pend.read_value = '0;
            n_pend.status     = ST_OK;
            case (i_in_item.func)
                FN_PUSH: begin
                    if (cnt_x >= cap_u) begin
                        n_pend.status     = ST_OVERFLOW;
                        n_pend.read_value = '1;
                    end else begin
                        ram_we  = 1'b1;
                        cnt_new = cnt_x + CMP_W'(1);
                    end
                end
                FN_POP: begin
                    if (cnt_x == '0) begin
                        n_pend.status     = ST_UNDERFLOW;
                        n_pend.read_value = '1;
                    end else begin
                        cnt_new   = cnt_x - CMP_W'(1);
                        ram_re    = 1'b1;
                        ram_raddr = cnt_new[ADDR_W-1:0];
                        n_need_rd = 1'b1;
                    end
                end
                FN_PEEK: begin
                    if (cnt_x == '0) begin
                        n_pend.status     = ST_UNDERFLOW;
                        n_pend.read_value = '1;
                    end else if (dep_x == '0 || dep_x > cnt_x) begin
                        n_pend.status     = ST_BAD_DEPTH;
                        n_pend.read_value = '1;
                    end else begin
                        ram_re    = 1'b1;
                        ram_raddr = ADDR_W'(cnt_x - dep_x);
                        n_need_rd = 1'b1;
                    end
                end
                default: begin
                    // unused code: no-op
                end
            endcase
            n_pend.entry_count = cnt_new[FLD_W-1:0];
            n_pend.is_empty    = (cnt_new == '0);
            n_pend.is_full     = (cnt_new >= cap_u);
        end
        n_count = cnt_new[CNT_W-1:0];
    end

    bsp_ram #(
        .P_WIDTH(WORD_W),
        .P_DEPTH(DEPTH)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(i_in_item.push_value),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    // merge the store read into the waiting result
    always_comb begin
        out_load = r_pend;
        if (r_need_rd) begin
            out_load.read_value = ram_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_cap       <= CAP_RST;
            r_out_valid <= 1'b0;
            r_need_rd   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_need_rd <= n_need_rd;
            if (i_cfg_valid && o_cfg_ready) begin
                r_cap <= i_cfg_data;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
        if (load_out) begin
            r_out_item <= out_load;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMP_W'(r_count) <= CMP_W'(DEPTH))
        else $error("entry count beyond store depth");

    a_load_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_state == S_LOAD)
        else $error("accepted beat did not start a store read");

    a_push_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |=> r_count == $past(r_count) + CNT_W'(1))
        else $error("push did not advance the count");

endmodule

`default_nettype wire
